### hdl/utc_to_local_time_with_dst_assert.svh
// Assertion macros for the local time block.
`ifndef UTC_TO_LOCAL_TIME_WITH_DST_ASSERT_SVH
`define UTC_TO_LOCAL_TIME_WITH_DST_ASSERT_SVH
`ifndef ASSERT_OFF
`define UTLD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: implication check failed");
`define UTLD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: next cycle check failed");
`else
`define UTLD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define UTLD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hdl/utld_pkg.sv
package utld_pkg;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_RULE   = 2'd1;
  localparam logic [1:0] MODE_MANUAL = 2'd2;

  localparam logic [2:0] CFG_ZONE   = 3'd0;
  localparam logic [2:0] CFG_MMIN   = 3'd1;
  localparam logic [2:0] CFG_USEMAN = 3'd2;
  localparam logic [2:0] CFG_MODE   = 3'd3;
  localparam logic [2:0] CFG_MSTEP  = 3'd4;
  localparam logic [2:0] CFG_SRULE  = 3'd5;
  localparam logic [2:0] CFG_ERULE  = 3'd6;
  localparam logic [2:0] CFG_SHIFT  = 3'd7;

  localparam int CFG_W = 21;

  localparam logic [33:0] SEC_YEAR     = 34'd31536000;
  localparam logic [33:0] SEC_LEAPYEAR = 34'd31622400;

  typedef enum logic [3:0] {
    ST_IDLE, ST_YSRCH, ST_CACHE, ST_RINIT, ST_RYEAR, ST_RMON,
    ST_RWEEK, ST_RMUL, ST_RADD, ST_APPLY, ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic ys_init;
    logic ys_step;
    logic cache_fill;
    logic ri_init;
    logic rule_end;
    logic ri_year;
    logic ri_mon;
    logic ri_week;
    logic ri_mul;
    logic ri_add;
    logic apply;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic rule_mode;
    logic ys_done;
    logic cache_hit;
    logic ry_done;
    logic rm_done;
    logic sel_end;
  } stat_t;

  // Gregorian leap test for year 1970 + y over the range the block covers
  function automatic logic is_leap(logic [8:0] y);
    logic [8:0] a;
    a = y + 9'd2;
    return (a[1:0] == 2'b00) && (y != 9'd130) && (y != 9'd230);
  endfunction

  function automatic logic [4:0] month_days(logic [3:0] m, logic leap);
    case (m)
      4'd1:    month_days = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: month_days = 5'd30;
      default: month_days = 5'd31;
    endcase
  endfunction

  function automatic logic [2:0] days_mod7(logic [4:0] d);
    case (d)
      5'd28:   days_mod7 = 3'd0;
      5'd29:   days_mod7 = 3'd1;
      5'd30:   days_mod7 = 3'd2;
      default: days_mod7 = 3'd3;
    endcase
  endfunction

  function automatic logic [2:0] add_mod7(logic [2:0] a, logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd7) s = s - 4'd7;
    return s[2:0];
  endfunction

endpackage

### hdl/utld_if.sv
interface utld_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] utc_seconds;
  modport source (output valid, output utc_seconds, input ready);
  modport sink (input valid, input utc_seconds, output ready);
endinterface

interface utld_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] local_seconds;
  logic        dst_active;
  modport source (output valid, output local_seconds, output dst_active, input ready);
  modport sink (input valid, input local_seconds, input dst_active, output ready);
endinterface

### hdl/utld_ctrl.sv
module utld_ctrl
  import utld_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t status,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // advance the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = status.rule_mode ? ST_YSRCH : ST_APPLY;
      ST_YSRCH: if (status.ys_done) state_nxt = ST_CACHE;
      ST_CACHE: state_nxt = status.cache_hit ? ST_APPLY : ST_RYEAR;
      ST_RINIT: state_nxt = ST_RYEAR;
      ST_RYEAR: if (status.ry_done) state_nxt = ST_RMON;
      ST_RMON:  if (status.rm_done) state_nxt = ST_RWEEK;
      ST_RWEEK: state_nxt = ST_RMUL;
      ST_RMUL:  state_nxt = ST_RADD;
      ST_RADD:  state_nxt = status.sel_end ? ST_APPLY : ST_RINIT;
      ST_APPLY: state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // drive datapath commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cmd.ys_init = 1'b1;
        end
      end
      ST_YSRCH: cmd.ys_step = !status.ys_done;
      ST_CACHE: begin
        if (!status.cache_hit) begin
          cmd.cache_fill = 1'b1;
          cmd.ri_init    = 1'b1;
        end
      end
      ST_RINIT: begin
        cmd.ri_init  = 1'b1;
        cmd.rule_end = 1'b1;
      end
      ST_RYEAR: cmd.ri_year  = !status.ry_done;
      ST_RMON:  cmd.ri_mon   = !status.rm_done;
      ST_RWEEK: cmd.ri_week  = 1'b1;
      ST_RMUL:  cmd.ri_mul   = 1'b1;
      ST_RADD:  cmd.ri_add   = 1'b1;
      ST_APPLY: cmd.apply    = 1'b1;
      ST_DONE:  cmd.out_load = !out_valid_r || out_ready;
      default:  cmd = '0;
    endcase
  end

  // hold a result until the receiver takes it
  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/utld_dp.sv
module utld_dp
  import utld_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output stat_t             status,
  input  logic [31:0]       in_utc,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output logic [31:0]       out_local,
  output logic              out_dst
);

  // configuration
  logic [16:0] zone_r;
  logic [11:0] mmin_r;
  logic        useman_r;
  logic [1:0]  mode_r;
  logic [2:0]  mstep_r;
  logic [20:0] srule_r, erule_r;
  logic [13:0] shift_r;

  // rule cache
  logic        cvalid_r;
  logic [7:0]  cyear_r;
  logic [31:0] start_r, end_r;

  // working registers
  logic [31:0] now_r;
  logic        act_r;
  logic [7:0]  year_r;
  logic [33:0] acc_r;
  logic        sel_r;
  logic [8:0]  tyear_r, ycnt_r;
  logic [3:0]  tmon_r, mcnt_r;
  logic [2:0]  wk_r, dow_r, wd_r;
  logic        last_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;
  logic [16:0] days_r;
  logic [31:0] prod_r;
  logic [31:0] out_local_r;
  logic        out_dst_r;

  // offset stage
  logic [32:0] zone_ext;
  logic [31:0] man_ext, man_add, now_in;
  assign zone_ext = {{16{zone_r[16]}}, zone_r};
  assign man_ext  = {{20{mmin_r[11]}}, mmin_r};
  assign man_add  = (man_ext << 6) - (man_ext << 2);
  always_comb begin
    if (useman_r) now_in = in_utc + man_add;
    else if ($signed({1'b0, in_utc}) > $signed(zone_ext)) now_in = in_utc + zone_ext[31:0];
    else now_in = in_utc;
  end

  // year search step
  logic [33:0] ys_acc_nxt;
  assign ys_acc_nxt = acc_r + (is_leap({1'b0, year_r}) ? SEC_LEAPYEAR : SEC_YEAR);

  // rule decode
  logic [20:0] rule;
  logic [2:0]  r_week, r_dow;
  logic [3:0]  r_mon, mon_c;
  assign rule   = cmd.rule_end ? erule_r : srule_r;
  assign r_week = rule[2:0];
  assign r_dow  = rule[5:3];
  assign r_mon  = rule[9:6];
  assign mon_c  = (r_mon > 4'd11) ? 4'd11 : r_mon;

  // year and month walk
  logic       yleap, tleap;
  logic [4:0] mlen;
  assign yleap = is_leap(ycnt_r);
  assign tleap = is_leap(tyear_r);
  assign mlen  = month_days(mcnt_r, tleap);

  // weekday alignment
  logic [3:0]  dd0, dd1, dd2;
  logic [16:0] wk_days;
  assign dd0 = {1'b0, dow_r} + 4'd7 - {1'b0, wd_r};
  assign dd1 = (dd0 >= 4'd7) ? dd0 - 4'd7 : dd0;
  assign dd2 = (dd1 >= 4'd7) ? dd1 - 4'd7 : dd1;
  assign wk_days = days_r + 17'(({3'b0, wk_r} - 6'd1) * 6'd7) + 17'(dd2)
                   - (last_r ? 17'd7 : 17'd0);

  // instant assembly
  logic [33:0] days_sec;
  logic [16:0] hsec;
  logic [11:0] msec;
  logic [31:0] inst;
  assign days_sec = {17'b0, days_r} * 34'd86400;
  assign hsec     = 17'(hour_r) * 17'd3600;
  assign msec     = 12'(min_r) * 12'd60;
  assign inst     = prod_r + 32'(hsec) + 32'(msec);

  // shift selection
  logic [31:0] shift_ext, step_ext, step_add;
  logic        step_ok, north, in_win;
  assign shift_ext = {{18{shift_r[13]}}, shift_r};
  assign step_ext  = {{29{mstep_r[2]}}, mstep_r};
  assign step_add  = step_ext * 32'd1800;
  assign step_ok   = (mstep_r == 3'b001) || (mstep_r == 3'b010) ||
                     (mstep_r == 3'b110) || (mstep_r == 3'b111);
  assign north     = end_r > start_r;
  assign in_win    = north ? (now_r >= start_r && now_r < end_r)
                           : (now_r < end_r || now_r >= start_r);

  assign status.rule_mode = (mode_r == MODE_RULE);
  assign status.ys_done   = (ys_acc_nxt > {2'b00, now_r}) || (year_r == 8'd255);
  assign status.cache_hit = cvalid_r && (cyear_r == year_r);
  assign status.ry_done   = (ycnt_r == tyear_r);
  assign status.rm_done   = (mcnt_r == tmon_r);
  assign status.sel_end   = sel_r;

  // configuration and cache control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r   <= '0;
      mmin_r   <= '0;
      useman_r <= 1'b0;
      mode_r   <= MODE_RULE;
      mstep_r  <= '0;
      srule_r  <= '0;
      erule_r  <= '0;
      shift_r  <= 14'd3600;
      cvalid_r <= 1'b0;
      cyear_r  <= '0;
      start_r  <= '0;
      end_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ZONE:   zone_r   <= cfg_wdata[16:0];
          CFG_MMIN:   mmin_r   <= cfg_wdata[11:0];
          CFG_USEMAN: useman_r <= cfg_wdata[0];
          CFG_MODE:   mode_r   <= cfg_wdata[1:0];
          CFG_MSTEP:  mstep_r  <= cfg_wdata[2:0];
          CFG_SRULE: begin
            srule_r  <= cfg_wdata[20:0];
            cvalid_r <= 1'b0;
          end
          CFG_ERULE: begin
            erule_r  <= cfg_wdata[20:0];
            cvalid_r <= 1'b0;
          end
          CFG_SHIFT:  shift_r  <= cfg_wdata[13:0];
          default: ;
        endcase
      end
      if (cmd.cache_fill) begin
        cvalid_r <= 1'b1;
        cyear_r  <= year_r;
      end
      if (cmd.ri_add) begin
        if (sel_r) end_r <= inst;
        else start_r <= inst;
      end
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now_r <= now_in;
      act_r <= 1'b0;
    end
    if (cmd.ys_init) begin
      year_r <= '0;
      acc_r  <= '0;
    end
    if (cmd.ys_step) begin
      year_r <= year_r + 8'd1;
      acc_r  <= ys_acc_nxt;
    end
    if (cmd.ri_init) begin
      sel_r  <= cmd.rule_end;
      dow_r  <= r_dow;
      hour_r <= rule[14:10];
      min_r  <= rule[20:15];
      days_r <= '0;
      wd_r   <= 3'd4;
      ycnt_r <= '0;
      mcnt_r <= '0;
      if (r_week == 3'd0) begin
        wk_r   <= 3'd1;
        last_r <= 1'b1;
        if (mon_c == 4'd11) begin
          tmon_r  <= 4'd0;
          tyear_r <= {1'b0, year_r} + 9'd1;
        end else begin
          tmon_r  <= mon_c + 4'd1;
          tyear_r <= {1'b0, year_r};
        end
      end else begin
        wk_r    <= r_week;
        last_r  <= 1'b0;
        tmon_r  <= mon_c;
        tyear_r <= {1'b0, year_r};
      end
    end
    if (cmd.ri_year) begin
      days_r <= days_r + (yleap ? 17'd366 : 17'd365);
      wd_r   <= add_mod7(wd_r, yleap ? 3'd2 : 3'd1);
      ycnt_r <= ycnt_r + 9'd1;
    end
    if (cmd.ri_mon) begin
      days_r <= days_r + 17'(mlen);
      wd_r   <= add_mod7(wd_r, days_mod7(mlen));
      mcnt_r <= mcnt_r + 4'd1;
    end
    if (cmd.ri_week) days_r <= wk_days;
    if (cmd.ri_mul) prod_r <= days_sec[31:0];
    if (cmd.apply) begin
      if (mode_r == MODE_MANUAL) begin
        if (step_ok) begin
          now_r <= now_r + step_add;
          act_r <= 1'b1;
        end
      end else if (mode_r == MODE_RULE) begin
        if (in_win) begin
          now_r <= now_r + shift_ext;
          act_r <= 1'b1;
        end
      end
    end
    if (cmd.out_load) begin
      out_local_r <= now_r;
      out_dst_r   <= act_r;
    end
  end

  assign out_local = out_local_r;
  assign out_dst   = out_dst_r;

endmodule

### hdl/utc_to_local_time_with_dst.sv
// UTC to local time converter with daylight saving rules.
// Input channel in_ch carries one UTC second count per request; output
// channel out_ch returns the local second count and the DST flag, one
// result per request, in order. Configuration writes go through cfg_we,
// cfg_index and cfg_wdata; the user must make them only while the block
// is idle, as the block itself does not enforce it. With DST off or in
// manual step mode the request goes straight to the apply step. In rule
// mode the year search walks one year per cycle, to the year index of the
// input (up to 136). On a year change or after a rule write the sequencer
// recomputes both instants, walking years and months one per cycle.
// One request is in work at a time; a new request is taken once the previous
// result sits in the output register, even while the receiver stalls it.
// A stalled result holds until taken; the next one waits behind it.
// Synchronous reset restores the configuration register defaults and drops the cached year.
`include "utc_to_local_time_with_dst_assert.svh"

module utc_to_local_time_with_dst
  import utld_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  utld_in_if.sink          in_ch,
  utld_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  cmd_t  cmd;
  stat_t status;

  utld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  utld_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_utc    (in_ch.utc_seconds),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_local (out_ch.local_seconds),
    .out_dst   (out_ch.dst_active)
  );

  // busy right after a request is taken
  `UTLD_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  // never overwrite a pending result
  `UTLD_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.out_load, !out_ch.valid || out_ch.ready)
  // capture only an offered request
  `UTLD_ASSERT_IMP(a_load_valid, clk, rst_n, cmd.load_in, in_ch.valid)

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import utld_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  utld_in_if in_ch();
  utld_out_if out_ch();

  utc_to_local_time_with_dst dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  typedef struct packed {
    logic [31:0] local_seconds;
    logic        dst_active;
  } local_res_t;

  // Shadow copy of the block's registers and DST cache
  logic signed [16:0] zone_off;
  logic signed [11:0] man_min;
  logic               use_man;
  logic [1:0]         mode;
  logic signed [2:0]  man_step;
  logic [20:0]        rule_start;
  logic [20:0]        rule_end;
  logic signed [13:0] shift_sec;
  logic [7:0]         year_cached;
  logic               year_ok;
  logic [31:0]        start_at;
  logic [31:0]        end_at;

  logic [31:0] utc_pending[$];
  local_res_t  local_expected[$];
  int mismatches = 0;
  int stray_results = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int dst_seen = 0;
  bit idle_on = 1;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic bit yr_is_leap(int y);
    int a;
    a = 1970 + y;
    return (a % 4 == 0) && ((a % 100 != 0) || (a % 400 == 0));
  endfunction

  function automatic longint days_to_year(int y);
    longint d;
    d = 365 * longint'(y);
    for (int i = 0; i < y; i++) if (yr_is_leap(i)) d++;
    return d;
  endfunction

  function automatic logic [7:0] year_index(logic [31:0] t);
    longint day;
    longint acc;
    int y;
    day = t / 86400;
    acc = 0;
    y = 0;
    forever begin
      acc += yr_is_leap(y) ? 366 : 365;
      if (acc > day || y >= 255) break;
      y++;
    end
    return y[7:0];
  endfunction

  function automatic logic [31:0] rule_time(logic [20:0] rule, int year);
    int mlen[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int week, dow, mon, hour, minute, y, m, w, wd;
    longint days, t;
    week = rule[2:0];
    dow = rule[5:3];
    mon = rule[9:6];
    hour = rule[14:10];
    minute = rule[20:15];
    y = year;
    if (mon > 11) mon = 11;
    m = mon;
    w = week;
    // last weekday: start from the first of the next month, December rolls over
    if (w == 0) begin
      m++;
      if (m > 11) begin
        m = 0;
        y++;
      end
      w = 1;
    end
    days = days_to_year(y);
    for (int i = 0; i < m; i++) days += (i == 1 && yr_is_leap(y)) ? 29 : mlen[i];
    wd = (days + 4) % 7;
    days += 7 * (w - 1) + ((dow + 7 - wd) % 7);
    if (week == 0) days -= 7;
    t = days * 86400 + hour * 3600 + minute * 60;
    return t[31:0];
  endfunction

  // Compute one local time result and update the DST cache
  function local_res_t convert_utc(logic [31:0] utc);
    logic [31:0] now;
    logic [7:0] y;
    bit north;
    local_res_t r;
    now = utc;
    r.dst_active = 1'b0;
    if (!use_man) begin
      if (longint'(utc) > longint'(zone_off)) now = utc + 32'(zone_off);
    end else begin
      now = utc + 32'(int'(man_min) * 60);
    end
    if (mode == MODE_MANUAL) begin
      if (man_step >= -2 && man_step <= 2 && man_step != 0) begin
        now += 32'(int'(man_step) * 1800);
        r.dst_active = 1'b1;
      end
    end else if (mode == MODE_RULE) begin
      y = year_index(now);
      if (!year_ok || year_cached != y) begin
        year_cached = y;
        year_ok = 1'b1;
        start_at = rule_time(rule_start, y);
        end_at = rule_time(rule_end, y);
      end
      north = end_at > start_at;
      if ((north && now >= start_at && now < end_at) ||
          (!north && (now < end_at || now >= start_at))) begin
        now += 32'(shift_sec);
        r.dst_active = 1'b1;
      end
    end
    r.local_seconds = now;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [20:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ZONE:   zone_off = val[16:0];
      CFG_MMIN:   man_min = val[11:0];
      CFG_USEMAN: use_man = val[0];
      CFG_MODE:   mode = val[1:0];
      CFG_MSTEP:  man_step = val[2:0];
      CFG_SRULE: begin
        rule_start = val;
        year_ok = 1'b0;
      end
      CFG_ERULE: begin
        rule_end = val;
        year_ok = 1'b0;
      end
      CFG_SHIFT:  shift_sec = val[13:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // check after the edge has settled so a request being loaded is seen
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (utc_pending.size() != 0 || local_expected.size() != 0 || in_ch.valid);
  endtask

  function automatic logic [20:0] pack_rule(int wk, int dw, int mo, int hr, int mi);
    return {6'(mi), 5'(hr), 4'(mo), 3'(dw), 3'(wk)};
  endfunction

  function automatic logic [20:0] rand_rule();
    if ($urandom_range(0, 4) == 0) return 21'($urandom);
    return pack_rule($urandom_range(0, 5), $urandom_range(0, 7), $urandom_range(0, 11),
                     $urandom_range(0, 23), $urandom_range(0, 59));
  endfunction

  // Driver: present pending requests, with random gaps
  int in_gap = 0;
  always @(posedge clk) begin
    logic        nv;
    logic [31:0] nd;
    nv = in_ch.valid;
    nd = in_ch.utc_seconds;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        local_expected.push_back(convert_utc(in_ch.utc_seconds));
        requests_sent++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (utc_pending.size() != 0) begin
          nv = 1'b1;
          nd = utc_pending.pop_front();
          if (idle_on && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 7);
        end
      end
    end
    in_ch.valid <= nv;
    in_ch.utc_seconds <= nd;
  end

  // Monitor: random backpressure, compare against the oldest expectation
  int out_gap = 0;
  always @(posedge clk) begin
    local_res_t exp_r;
    logic nr;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (local_expected.size() == 0) begin
        stray_results++;
        $display("unexpected result local=%h dst=%b", out_ch.local_seconds, out_ch.dst_active);
      end else begin
        exp_r = local_expected.pop_front();
        results_checked++;
        if (exp_r.dst_active) dst_seen++;
        if (exp_r.local_seconds !== out_ch.local_seconds ||
            exp_r.dst_active !== out_ch.dst_active) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected local=%h dst=%b, got local=%h dst=%b",
                     exp_r.local_seconds, exp_r.dst_active,
                     out_ch.local_seconds, out_ch.dst_active);
        end
      end
    end
    nr = 1'b1;
    if (out_gap > 0) begin
      out_gap--;
      nr = 1'b0;
    end else if (idle_on && $urandom_range(0, 6) == 0) begin
      out_gap = $urandom_range(1, 7);
      nr = 1'b0;
    end
    out_ch.ready <= nr;
  end

  initial begin
    #40_000_000;
    $display("utc_to_local_time_with_dst regression: fail");
    $finish;
  end

  initial begin
    logic [31:0] base;
    in_ch.valid = 1'b0;
    in_ch.utc_seconds = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ZONE;
    cfg_wdata = '0;
    rst_n = 1'b0;
    zone_off = 0; man_min = 0; use_man = 0; mode = MODE_RULE; man_step = 0;
    rule_start = 0; rule_end = 0; shift_sec = 3600;
    year_cached = 0; year_ok = 0; start_at = 0; end_at = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults, field extremes
    utc_pending.push_back(32'd0);
    utc_pending.push_back(32'hFFFF_FFFF);
    utc_pending.push_back(32'h8000_0000);
    wait_drained();

    // European style rule, zone offset boundary around utc == offset
    write_reg(CFG_SRULE, pack_rule(0, 0, 2, 2, 0));
    write_reg(CFG_ERULE, pack_rule(0, 0, 9, 3, 0));
    write_reg(CFG_ZONE, 21'(3600));
    utc_pending.push_back(32'd3600);
    utc_pending.push_back(32'd3601);
    utc_pending.push_back(32'd1_700_000_000);
    utc_pending.push_back(32'd1_690_000_000);
    wait_drained();

    // Negative zone extreme, southern window, December last-week rollover
    write_reg(CFG_ZONE, 21'(-50400));
    write_reg(CFG_SRULE, pack_rule(0, 6, 11, 31, 63));
    write_reg(CFG_ERULE, pack_rule(1, 7, 15, 0, 0));
    write_reg(CFG_SHIFT, 21'(-7200));
    utc_pending.push_back(32'd0);
    utc_pending.push_back(32'd1_703_900_000);
    utc_pending.push_back(32'd1_672_600_000);
    utc_pending.push_back(32'hFFFF_FFFF);
    wait_drained();

    // Large week counts, positive extremes
    write_reg(CFG_ZONE, 21'(50400));
    write_reg(CFG_SRULE, pack_rule(7, 3, 0, 0, 0));
    write_reg(CFG_ERULE, pack_rule(5, 1, 12, 23, 59));
    write_reg(CFG_SHIFT, 21'(7200));
    utc_pending.push_back(32'd50400);
    utc_pending.push_back(32'd1_000_000_000);
    utc_pending.push_back(32'd4_000_000_000);
    wait_drained();

    // Manual offset and manual step, including out-of-range steps
    write_reg(CFG_USEMAN, 21'(1));
    write_reg(CFG_MODE, 21'(MODE_MANUAL));
    for (int s = -4; s <= 3; s++) begin
      write_reg(CFG_MSTEP, 21'(s));
      write_reg(CFG_MMIN, 21'(s[0] ? -1440 : 1440));
      utc_pending.push_back(32'd10);
      wait_drained();
    end
    write_reg(CFG_MODE, 21'(MODE_OFF));
    utc_pending.push_back(32'hFFFF_FF00);
    wait_drained();
    write_reg(CFG_MODE, 21'(3));
    utc_pending.push_back(32'd5);
    wait_drained();

    // Random phases with random settings
    for (int ph = 0; ph < 25; ph++) begin
      if (ph >= 21) idle_on = 0;
      write_reg(CFG_ZONE, 21'($urandom_range(0, 100800) - 50400));
      write_reg(CFG_MMIN, 21'($urandom_range(0, 2880) - 1440));
      write_reg(CFG_USEMAN, 21'($urandom_range(0, 3) == 0));
      write_reg(CFG_MODE, 21'($urandom_range(0, 5) < 4 ? MODE_RULE : $urandom_range(0, 3)));
      write_reg(CFG_MSTEP, 21'($urandom_range(0, 7)));
      write_reg(CFG_SRULE, rand_rule());
      write_reg(CFG_ERULE, rand_rule());
      write_reg(CFG_SHIFT, 21'($urandom_range(0, 14400) - 7200));
      base = $urandom;
      for (int k = 0; k < 50; k++) begin
        // mostly walk within a year so the cache and both windows are hit
        case ($urandom_range(0, 3))
          0: base = $urandom;
          1: base = base + $urandom_range(0, 40_000_000) - 20_000_000;
          default: base = base + $urandom_range(0, 200_000) - 100_000;
        endcase
        utc_pending.push_back(base);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d requests, %0d results checked, %0d with DST applied",
             requests_sent, results_checked, dst_seen);
    $display("settings swept: zone and manual offsets, rule, manual and off modes");
    if (mismatches == 0 && stray_results == 0 && local_expected.size() == 0) begin
      $display("utc_to_local_time_with_dst regression: pass");
    end else begin
      $display("utc_to_local_time_with_dst regression: fail");
    end
    $finish;
  end

endmodule
